[src/assert_macros.svh]
// Assertion helpers. Both need clk_i in the enclosing module; ASSERT_CLK also needs rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising clock edge while reset is released.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Checked on every rising clock edge, also during reset.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(label, prop)
`define ASSERT_ALWAYS(label, prop)

`endif

`endif

[src/dfrne_pkg.sv]
package dfrne_pkg;

  // Input sample format.
  localparam int SampleW    = 16;
  localparam int SampleBits = 16;
  localparam logic [SampleW-1:0] SampleMask = SampleW'((1 << SampleBits) - 1);

  // Capacity and accumulator widths.
  localparam int MaxPixels = 16777216;
  localparam int CountW    = 25;
  localparam int DiffW     = SampleBits + 1;
  localparam int SqW       = 2 * SampleBits;
  localparam int SumW      = 41;
  localparam int SqSumW    = 57;

  // Back end arithmetic widths.
  localparam int ProdW   = CountW + SqSumW;
  localparam int ShiftQ  = 15;
  localparam int XW      = ProdW + ShiftQ + 1;
  localparam int RootW   = XW / 2;
  localparam int RemW    = RootW + 3;
  localparam int NoiseW  = 24;
  localparam int CntW    = $clog2(RootW + 1);

  localparam int MulSteps  = SumW;
  localparam int SqrtSteps = RootW;
  localparam int DivSteps  = RootW;

  localparam int FifoDepth = 2;
  localparam int PtrW      = $clog2(FifoDepth);

  // Snapshot of one frame's accumulators, handed from front to back.
  typedef struct packed {
    logic signed [SumW-1:0] diff_sum;
    logic [SqSumW-1:0]      square_sum;
    logic [CountW-1:0]      pair_count;
    logic                   dropped;
  } frame_stats_t;

  typedef struct packed {
    logic [NoiseW-1:0] noise_est;
    logic [CountW-1:0] pixels_used;
    logic              overflow;
  } result_t;

endpackage

[src/dfrne_front.sv]
`include "assert_macros.svh"

module dfrne_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [dfrne_pkg::SampleW-1:0] a_i,
  input  logic [dfrne_pkg::SampleW-1:0] b_i,
  input  logic                         last_i,
  output logic                         stats_valid_o,
  input  logic                         stats_ready_i,
  output dfrne_pkg::frame_stats_t      stats_o
);
  import dfrne_pkg::*;

  logic [SampleW-1:0]     a_m, b_m;
  logic signed [DiffW-1:0] diff;
  logic [DiffW-1:0]       mag_w;
  logic [SampleBits-1:0]  mag;
  logic [SqW-1:0]         sq;

  logic                   p_vld_q;
  logic                   p_last_q;
  logic signed [DiffW-1:0] p_diff_q;
  logic [SqW-1:0]         p_sq_q;
  logic                   p_go;
  logic                   room;

  logic signed [SumW-1:0] sum_q, sum_nx;
  logic [SqSumW-1:0]      sqsum_q, sqsum_nx;
  logic [CountW-1:0]      count_q, count_nx;
  logic                   drop_q, drop_nx;

  // First stage: difference and its square.
  always_comb begin
    a_m   = a_i & SampleMask;
    b_m   = b_i & SampleMask;
    diff  = $signed({1'b0, a_m[SampleBits-1:0]}) - $signed({1'b0, b_m[SampleBits-1:0]});
    mag_w = diff[DiffW-1] ? (~diff + DiffW'(1)) : diff;
    mag   = mag_w[SampleBits-1:0];
    sq    = mag * mag;
  end

  // The second stage only stalls on a frame end when the queue is full.
  assign p_go       = p_vld_q && (!p_last_q || stats_ready_i);
  assign in_ready_o = !p_vld_q || p_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      p_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      p_last_q <= last_i;
      p_diff_q <= diff;
      p_sq_q   <= sq;
    end
  end

  always_comb begin
    room     = count_q < CountW'(MaxPixels);
    sum_nx   = sum_q;
    sqsum_nx = sqsum_q;
    count_nx = count_q;
    drop_nx  = drop_q;
    if (room) begin
      sum_nx   = sum_q + {{(SumW-DiffW){p_diff_q[DiffW-1]}}, p_diff_q};
      sqsum_nx = sqsum_q + {{(SqSumW-SqW){1'b0}}, p_sq_q};
      count_nx = count_q + CountW'(1);
    end else begin
      drop_nx  = 1'b1;
    end
  end

  assign stats_valid_o       = p_vld_q && p_last_q;
  assign stats_o.diff_sum    = sum_nx;
  assign stats_o.square_sum  = sqsum_nx;
  assign stats_o.pair_count  = count_nx;
  assign stats_o.dropped     = drop_nx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      sqsum_q <= '0;
      count_q <= '0;
      drop_q  <= 1'b0;
    end else if (p_go) begin
      if (p_last_q) begin
        sum_q   <= '0;
        sqsum_q <= '0;
        count_q <= '0;
        drop_q  <= 1'b0;
      end else begin
        sum_q   <= sum_nx;
        sqsum_q <= sqsum_nx;
        count_q <= count_nx;
        drop_q  <= drop_nx;
      end
    end
  end

  `ASSERT_CLK(count_within_capacity, count_q <= CountW'(MaxPixels))
  `ASSERT_CLK(frame_end_cleared, (p_go && p_last_q) |=> (count_q == '0 && !drop_q))

endmodule

[src/dfrne_fifo.sv]
`include "assert_macros.svh"

module dfrne_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_valid_i,
  output logic                    push_ready_o,
  input  dfrne_pkg::frame_stats_t push_data_i,
  output logic                    pop_valid_o,
  input  logic                    pop_ready_i,
  output dfrne_pkg::frame_stats_t pop_data_o
);
  import dfrne_pkg::*;

  localparam int CntBits = $clog2(FifoDepth + 1);

  frame_stats_t        mem_q [FifoDepth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0]  cnt_q;
  logic                do_push, do_pop;

  assign push_ready_o = cnt_q != CntBits'(FifoDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntBits'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntBits'(1);
      end
    end
  end

  `ASSERT_CLK(fifo_count_bounded, cnt_q <= CntBits'(FifoDepth))

endmodule

[src/dfrne_back.sv]
`include "assert_macros.svh"

module dfrne_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    stats_valid_i,
  output logic                    stats_ready_o,
  input  dfrne_pkg::frame_stats_t stats_i,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output dfrne_pkg::result_t      res_o
);
  import dfrne_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StSub  = 3'd2;
  localparam logic [2:0] StSqrt = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  logic [2:0]         state_q;
  logic [CntW-1:0]    cnt_q;

  logic [CountW-1:0]  n_q;
  logic               drop_q;

  // Shift-and-add multipliers for n*Q and S*S.
  logic [ProdW-1:0]   nq_q, ss_q, mc_nq_q, mc_ss_q;
  logic [CountW-1:0]  mp_n_q;
  logic [SumW-1:0]    mp_s_q;
  logic [SumW-1:0]    smag;

  // Restoring square root, two radicand bits per step.
  logic [XW-1:0]      x_q;
  logic [RemW-1:0]    rem_q, rem_sh, trial;
  logic [RootW-1:0]   root_q;

  // Restoring division of the root by n.
  logic [RootW-1:0]   dvd_q, quo_q;
  logic [CountW-1:0]  drem_q;
  logic [CountW:0]    drem_sh;

  logic [ProdW-1:0]   var_v;
  logic [NoiseW-1:0]  noise;

  logic               out_vld_q;
  result_t            out_q;

  assign stats_ready_o = state_q == StIdle;

  always_comb begin
    smag    = stats_i.diff_sum[SumW-1] ? (~stats_i.diff_sum + SumW'(1))
                                       : stats_i.diff_sum;
    var_v   = (nq_q >= ss_q) ? (nq_q - ss_q) : '0;
    rem_sh  = {rem_q[RemW-3:0], x_q[XW-1:XW-2]};
    trial   = {{(RemW-RootW-2){1'b0}}, root_q, 2'b01};
    drem_sh = {drem_q, dvd_q[RootW-1]};
    if (n_q == '0) begin
      noise = '0;
    end else if (quo_q > RootW'({NoiseW{1'b1}})) begin
      noise = '1;
    end else begin
      noise = quo_q[NoiseW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_vld_q && res_ready_i && state_q != StDone) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (stats_valid_i) begin
            state_q <= StMul;
            cnt_q   <= '0;
          end
        end
        StMul: begin
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == CntW'(MulSteps - 1)) begin
            state_q <= StSub;
          end
        end
        StSub: begin
          state_q <= StSqrt;
          cnt_q   <= '0;
        end
        StSqrt: begin
          if (cnt_q == CntW'(SqrtSteps - 1)) begin
            state_q <= StDiv;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + CntW'(1);
          end
        end
        StDiv: begin
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == CntW'(DivSteps - 1)) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (!out_vld_q || res_ready_i) begin
            out_vld_q <= 1'b1;
            state_q   <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (stats_valid_i) begin
          n_q     <= stats_i.pair_count;
          drop_q  <= stats_i.dropped;
          nq_q    <= '0;
          ss_q    <= '0;
          mc_nq_q <= {{(ProdW-SqSumW){1'b0}}, stats_i.square_sum};
          mc_ss_q <= {{(ProdW-SumW){1'b0}}, smag};
          mp_n_q  <= stats_i.pair_count;
          mp_s_q  <= smag;
        end
      end
      StMul: begin
        if (mp_n_q[0]) begin
          nq_q <= nq_q + mc_nq_q;
        end
        if (mp_s_q[0]) begin
          ss_q <= ss_q + mc_ss_q;
        end
        mc_nq_q <= {mc_nq_q[ProdW-2:0], 1'b0};
        mc_ss_q <= {mc_ss_q[ProdW-2:0], 1'b0};
        mp_n_q  <= mp_n_q >> 1;
        mp_s_q  <= mp_s_q >> 1;
      end
      StSub: begin
        x_q    <= {{(XW-ProdW-ShiftQ){1'b0}}, var_v, {ShiftQ{1'b0}}};
        rem_q  <= '0;
        root_q <= '0;
      end
      StSqrt: begin
        x_q <= {x_q[XW-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[RootW-2:0], 1'b0};
        end
        if (cnt_q == CntW'(SqrtSteps - 1)) begin
          drem_q <= '0;
          quo_q  <= '0;
          if (rem_sh >= trial) begin
            dvd_q <= {root_q[RootW-2:0], 1'b1};
          end else begin
            dvd_q <= {root_q[RootW-2:0], 1'b0};
          end
        end
      end
      StDiv: begin
        dvd_q <= {dvd_q[RootW-2:0], 1'b0};
        if (drem_sh >= {1'b0, n_q}) begin
          drem_q <= CountW'(drem_sh - {1'b0, n_q});
          quo_q  <= {quo_q[RootW-2:0], 1'b1};
        end else begin
          drem_q <= drem_sh[CountW-1:0];
          quo_q  <= {quo_q[RootW-2:0], 1'b0};
        end
      end
      StDone: begin
        if (!out_vld_q || res_ready_i) begin
          out_q.noise_est   <= noise;
          out_q.pixels_used <= n_q;
          out_q.overflow    <= drop_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

  `ASSERT_CLK(result_loaded_from_done, $rose(out_vld_q) |-> $past(state_q) == StDone)
  `ASSERT_CLK(sqrt_remainder_bounded, (state_q == StSqrt) |-> rem_q <= {root_q, 1'b0})
  `ASSERT_CLK(div_remainder_bounded, (state_q == StDiv && n_q != '0) |-> drem_q < n_q)
  `ASSERT_ALWAYS(no_pop_while_busy, (state_q != StIdle) |-> !stats_ready_o)

endmodule

[src/dark_frame_read_noise_estimator.sv]
// Throughput: one pixel pair per cycle; a frame end stalls the input only while two
// finished frames already wait in the queue.
// Result path: the last pair goes through the queue write, back-end load, 41 multiply,
// 1 subtract, 49 square-root and 49 divide steps, then the output register.
// Reset: asynchronous, active low; clears the accumulators, queue and output.
module dark_frame_read_noise_estimator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // dark_a_sample[15:0], dark_b_sample[31:16]
  input  logic        s_axis_tlast,  // last_pixel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // noise_est[23:0], pixels_used[48:24], zero
  output logic        m_axis_tuser   // overflow
);
  import dfrne_pkg::*;

  logic         push_valid, push_ready;
  frame_stats_t push_data;
  logic         pop_valid, pop_ready;
  frame_stats_t pop_data;
  result_t      res;

  dfrne_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .a_i           (s_axis_tdata[SampleW-1:0]),
    .b_i           (s_axis_tdata[2*SampleW-1:SampleW]),
    .last_i        (s_axis_tlast),
    .stats_valid_o (push_valid),
    .stats_ready_i (push_ready),
    .stats_o       (push_data)
  );

  dfrne_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  dfrne_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stats_valid_i (pop_valid),
    .stats_ready_o (pop_ready),
    .stats_i       (pop_data),
    .res_valid_o   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_o         (res)
  );

  assign m_axis_tdata = {{(56-NoiseW-CountW){1'b0}}, res.pixels_used, res.noise_est};
  assign m_axis_tuser = res.overflow;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import dfrne_pkg::*;

  localparam int CycleLimit = 500000;
  localparam int HoldCycles = 1000;
  localparam int TailCycles = 200;
  localparam int RandomItems = 420;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tuser;

  // Frame accumulators of the predictor.
  longint      diff_total;
  logic [63:0] square_total;
  logic [31:0] pair_total;
  logic        frame_dropped;

  result_t     noise_results_q[$];
  int          mismatch_count = 0;
  int          pairs_accepted = 0;
  int          cycle_count = 0;

  // Sender burst control, used only by the stimulus process.
  bit          gaps_enabled = 1'b0;
  int          burst_left = 0;

  // Receiver control: the stimulus writes the ready percentage and hold requests, the receiver tracks the hold.
  int          sink_ready_pct = 100;
  int          hold_reqs = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  dark_frame_read_noise_estimator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [63:0] isqrt128(input logic [127:0] x);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] sq;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      c  = r | (64'd1 << k);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= x) r = c;
    end
    return r;
  endfunction

  function automatic void clear_frame();
    diff_total    = 0;
    square_total  = '0;
    pair_total    = '0;
    frame_dropped = 1'b0;
  endfunction

  // Folds one accepted pair into the frame and, on the last pair, queues the
  // noise estimate floor(isqrt(32768 * (n*Q - S*S)) / n), saturated to 24 bits.
  function automatic void predict_pair(input logic [15:0] a_raw, input logic [15:0] b_raw,
                                       input logic last);
    logic [15:0]  a;
    logic [15:0]  b;
    longint       d;
    logic [63:0]  n;
    logic [63:0]  s_mag;
    logic [127:0] nq;
    logic [127:0] ss;
    logic [127:0] v;
    logic [63:0]  quot;
    result_t      r;
    a = a_raw & SampleMask;
    b = b_raw & SampleMask;
    if (pair_total < MaxPixels) begin
      d = longint'(a) - longint'(b);
      diff_total   += d;
      square_total += 64'(d * d);
      pair_total++;
    end else begin
      frame_dropped = 1'b1;
    end
    if (last) begin
      n    = 64'(pair_total);
      quot = '0;
      if (n != 0) begin
        s_mag = (diff_total < 0) ? 64'(-diff_total) : 64'(diff_total);
        nq    = {64'd0, n} * {64'd0, square_total};
        ss    = {64'd0, s_mag} * {64'd0, s_mag};
        v     = (ss <= nq) ? nq - ss : '0;
        quot  = isqrt128(v << 15) / n;
        if (quot > 64'hFF_FFFF) quot = 64'hFF_FFFF;
      end
      r.noise_est   = quot[NoiseW-1:0];
      r.pixels_used = pair_total[CountW-1:0];
      r.overflow    = frame_dropped;
      noise_results_q.push_back(r);
      clear_frame();
    end
  endfunction

  // Offers one pixel pair and returns once the transaction has completed.
  // The valid stays high afterwards unless a gap starts.
  task automatic send_pair(input logic [15:0] a, input logic [15:0] b, input logic last);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_pair(a, b, last);
    pairs_accepted++;
    if (gaps_enabled) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 24);
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic idle_sender(input int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic test_single_pixel_frames();
    send_pair(16'hFFFF, 16'h0000, 1'b1);
    send_pair(16'h0000, 16'hFFFF, 1'b1);
    send_pair(16'h0000, 16'h0000, 1'b1);
    send_pair(16'hFFFF, 16'hFFFF, 1'b1);
  endtask

  // Every difference equal, so the variance and the noise are zero.
  task automatic test_constant_difference();
    logic [15:0] a;
    for (int i = 0; i < 6; i++) begin
      a = 16'd1234 + 16'(i * 9000);
      send_pair(a, a - 16'd1234, i == 5);
    end
  endtask

  // Differences of plus and minus full scale give the largest variance.
  task automatic test_extreme_spread();
    for (int i = 0; i < 8; i++) begin
      if (i % 2 == 0) send_pair(16'hFFFF, 16'h0000, i == 7);
      else            send_pair(16'h0000, 16'hFFFF, i == 7);
    end
  endtask

  task automatic test_walking_bits();
    for (int i = 0; i < 6; i++) begin
      send_pair(16'h0001 << (i * 3), ~(16'h0001 << (i * 3)), i == 5);
    end
  endtask

  // The receiver holds off for a long stretch while short frames keep coming,
  // so the frame statistics queue fills and the input must stall.
  task automatic test_output_backpressure();
    gaps_enabled = 1'b0;
    hold_reqs <= hold_reqs + 1;
    for (int f = 0; f < 12; f++) begin
      send_pair(16'($urandom), 16'($urandom), 1'b0);
      send_pair(16'($urandom), 16'($urandom), 1'b1);
    end
  endtask

  task automatic test_random_frames();
    int          frame_len;
    int          style;
    int          pct_pick;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] off;
    int          start_count;
    start_count = pairs_accepted;
    while (pairs_accepted - start_count < RandomItems) begin
      gaps_enabled = ($urandom_range(0, 3) != 0);
      pct_pick = $urandom_range(0, 3);
      case (pct_pick)
        0:       sink_ready_pct <= 100;
        1:       sink_ready_pct <= 75;
        2:       sink_ready_pct <= 40;
        default: sink_ready_pct <= 15;
      endcase
      frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 12);
      style     = $urandom_range(0, 3);
      off       = 16'($urandom);
      for (int i = 0; i < frame_len; i++) begin
        case (style)
          0: begin
            a = 16'($urandom);
            b = 16'($urandom);
          end
          1: begin
            // Typical dark data: the two frames differ only in the low bits.
            a = 16'($urandom);
            b = a ^ 16'($urandom_range(0, 63));
          end
          2: begin
            a = 16'($urandom_range(int'(off), 65535));
            b = a - off;
          end
          default: begin
            a = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            b = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          end
        endcase
        send_pair(a, b, i == frame_len - 1);
      end
    end
  endtask

  // Receiver: a random ready pattern, or a counted hold when one is requested.
  always @(posedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen     <= hold_reqs;
      hold_left     <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) < sink_ready_pct);
    end
  end

  function automatic void check_field(input string field, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (noise_results_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: result transaction with none expected, tdata %h", $realtime,
                   m_axis_tdata);
        end
      end else begin
        want = noise_results_q.pop_front();
        check_field("noise_est", want.noise_est, m_axis_tdata[23:0]);
        check_field("pixels_used", want.pixels_used, m_axis_tdata[48:24]);
        check_field("overflow", want.overflow, m_axis_tuser);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("dark_frame_read_noise_estimator test failed");
      $finish;
    end
  end

  // Filling the full pixel capacity takes far longer than this run allows,
  // so frames here stay small and the overflow flag is expected low.
  initial begin
    clear_frame();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_pixel_frames();
    test_constant_difference();
    test_extreme_spread();
    test_walking_bits();
    test_output_backpressure();
    test_random_frames();

    idle_sender(1);
    sink_ready_pct <= 100;
    while (noise_results_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (mismatch_count == 0 && noise_results_q.size() == 0) begin
      $display("dark_frame_read_noise_estimator test passed");
    end else begin
      $display("dark_frame_read_noise_estimator test failed");
    end
    $finish;
  end

endmodule
